// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the query parameter extractor checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QPX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qpx assertion failed");

// next-cycle implication
`define QPX_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qpx assertion failed");

`endif

// ===== design/qpx_pkg.sv =====
// ----------------------------------------------------------------------------
// qpx_pkg
// Shared constants, types and helpers of the query parameter extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qpx_pkg;

   localparam int unsigned NAME_MAX_DEFAULT = 8;
   localparam int unsigned CSR_INDEX_W      = 2;
   localparam int unsigned CSR_DATA_W       = 64;
   localparam int unsigned QUEUE_DEPTH      = 2;
   localparam int unsigned MAX_VALUES       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_BYTES     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_CAPACITY = 2'd2;

   localparam logic [7:0] CAPACITY_RESET = 8'd32;

   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_EQ  = 8'h3D;
   localparam logic [7:0] CH_PCT = 8'h25;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam logic [4:0] HEX_NONE = 5'd16;

   // results caused by one item: up to three value bytes, then an optional status
   typedef struct packed {
      logic [MAX_VALUES-1:0][7:0] vals;
      logic [1:0]                 nv;
      logic                       st;
      logic                       fnd;
   } bundle_type;

   function automatic logic [4:0] hex_of(input logic [7:0] b);
      logic [4:0] r;
      r = HEX_NONE;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = 5'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = 5'(b - 8'h61 + 8'd10);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = 5'(b - 8'h41 + 8'd10);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/qpx_if.sv =====
// ----------------------------------------------------------------------------
// qpx_if
// Valid/ready channels for query bytes and extracted results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qpx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_last;
   modport source (output valid, ch, is_last, input ready);
   modport sink   (input valid, ch, is_last, output ready);
endinterface

interface qpx_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_byte;
   logic       found;
   logic       run_end;
   modport source (output valid, kind, out_byte, found, run_end, input ready);
   modport sink   (input valid, kind, out_byte, found, run_end, output ready);
endinterface

`default_nettype wire

// ===== design/url_query_param_extract.sv =====
// ----------------------------------------------------------------------------
// url_query_param_extract
// Query string parameter extractor with percent decoding.
// ----------------------------------------------------------------------------
// The block takes one query byte per cycle while its bundle queue has room, and
// returns the decoded value bytes of the configured parameter, then one status item
// when the string ends. An input byte is accepted whenever the two-entry bundle queue
// has room; a byte that causes k results (at most four) holds the output serializer
// until all k are handed out, so bytes with zero or one result sustain one item per
// cycle while the output is ready, and a replayed escape holds the serializer for each
// extra byte. Results pass through the bundle queue and then the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module url_query_param_extract #(
   parameter int unsigned NAME_MAX_BYTES = qpx_pkg::NAME_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   qpx_req_if.sink                         req_bus,
   qpx_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [qpx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qpx_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                q_push;
   qpx_pkg::bundle_type q_data;
   logic                q_full;
   logic                q_pop;
   logic                q_not_empty;
   qpx_pkg::bundle_type q_head;

   qpx_front #(
      .NAME_MAX_BYTES (NAME_MAX_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ch      (req_bus.ch),
      .req_is_last (req_bus.is_last),
      .req_ready   (req_bus.ready),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   qpx_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   qpx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_kind     (rsp_bus.kind),
      .rsp_out_byte (rsp_bus.out_byte),
      .rsp_found    (rsp_bus.found),
      .rsp_run_end  (rsp_bus.run_end)
   );

endmodule

`default_nettype wire

// ===== design/qpx_front.sv =====
// ----------------------------------------------------------------------------
// qpx_front
// Takes one query byte per cycle while the queue is not full, runs name match and
// percent decode, and pushes the bundle of results the byte causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpx_front #(
   parameter int unsigned NAME_MAX_BYTES = qpx_pkg::NAME_MAX_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic [7:0]                         req_ch,
   input  logic                               req_is_last,
   output logic                               req_ready,
   input  logic                               csr_we,
   input  logic [qpx_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qpx_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               q_full,
   output logic                               q_push,
   output qpx_pkg::bundle_type                q_data
);

   localparam int unsigned NAME_BITS = 8 * NAME_MAX_BYTES;

   typedef enum logic [1:0] {
      PH_MATCH = 2'd0,
      PH_SKIP  = 2'd1,
      PH_VALUE = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_type;

   typedef struct packed {
      phase_type                           phase;
      logic [3:0]                          mpos;
      esc_type                             esc;
      logic [7:0]                          hd;
      logic [7:0]                          cnt;
      logic                                fflag;
      logic [qpx_pkg::MAX_VALUES-1:0][7:0] vals;
      logic [1:0]                          nv;
      logic                                st;
      logic                                fnd;
   } acc_type;

   logic [NAME_BITS-1:0] name_ff;
   logic [3:0]           name_len_ff;
   logic [7:0]           cap_ff;

   phase_type  phase_ff;
   logic [3:0] mpos_ff;
   esc_type    esc_ff;
   logic [7:0] hd_ff;
   logic [7:0] cnt_ff;
   logic       fflag_ff;

   logic [3:0] len_eff;
   logic       accept;
   acc_type    acc;

   function automatic acc_type f_emit(input acc_type a, input logic [7:0] b,
                                      input logic [7:0] cap);
      if (a.phase == PH_VALUE) begin
         a.vals[a.nv] = b;
         a.nv  = a.nv + 2'd1;
         a.cnt = a.cnt + 8'd1;
         if ({1'b0, a.cnt} + 9'd1 >= {1'b0, cap}) begin
            a.phase = PH_DONE;
         end
      end
      return a;
   endfunction

   function automatic acc_type f_plain(input acc_type a, input logic [7:0] b,
                                       input logic [7:0] cap);
      if (a.phase == PH_VALUE) begin
         if (b == qpx_pkg::CH_AMP) begin
            a.phase = PH_DONE;
         end else if (b == qpx_pkg::CH_PCT) begin
            a.esc = ESC_PCT;
         end else begin
            a = f_emit(a, b, cap);
         end
      end
      return a;
   endfunction

   function automatic acc_type f_value(input acc_type a, input logic [7:0] b,
                                       input logic [7:0] cap);
      logic [4:0] h;
      logic [4:0] hh;
      h  = qpx_pkg::hex_of(b);
      hh = qpx_pkg::hex_of(a.hd);
      unique case (a.esc)
         ESC_NONE: begin
            a = f_plain(a, b, cap);
         end
         ESC_PCT: begin
            if (h != qpx_pkg::HEX_NONE) begin
               a.esc = ESC_DIGIT;
               a.hd  = b;
            end else begin
               a.esc = ESC_NONE;
               a = f_emit(a, qpx_pkg::CH_PCT, cap);
               a = f_plain(a, b, cap);
            end
         end
         default: begin
            a.esc = ESC_NONE;
            if (h != qpx_pkg::HEX_NONE) begin
               a = f_emit(a, {hh[3:0], h[3:0]}, cap);
            end else begin
               a = f_emit(a, qpx_pkg::CH_PCT, cap);
               a = f_plain(a, a.hd, cap);
               a = f_plain(a, b, cap);
            end
         end
      endcase
      return a;
   endfunction

   function automatic acc_type f_process(input acc_type a, input logic [7:0] b,
                                         input logic [7:0] cap, input logic [3:0] len,
                                         input logic [NAME_BITS-1:0] name);
      logic [NAME_BITS-1:0] sh;
      sh = name >> {a.mpos, 3'b000};
      unique case (a.phase)
         PH_MATCH: begin
            if (a.mpos < len) begin
               if (b == qpx_pkg::CH_AMP) begin
                  a.mpos = 4'd0;
               end else if (b == sh[7:0]) begin
                  a.mpos = a.mpos + 4'd1;
               end else begin
                  a.phase = PH_SKIP;
               end
            end else if (b == qpx_pkg::CH_EQ) begin
               a.fflag = 1'b1;
               a.phase = (cap < 8'd2) ? PH_DONE : PH_VALUE;
            end else if (b == qpx_pkg::CH_AMP) begin
               a.fflag = 1'b1;
               a.phase = PH_DONE;
            end else begin
               a.phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (b == qpx_pkg::CH_AMP) begin
               a.phase = PH_MATCH;
               a.mpos  = 4'd0;
            end
         end
         PH_VALUE: begin
            a = f_value(a, b, cap);
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   function automatic acc_type f_finish(input acc_type a, input logic [7:0] cap,
                                        input logic [3:0] len);
      esc_type held;
      held = a.esc;
      if (a.phase == PH_VALUE && held != ESC_NONE) begin
         a.esc = ESC_NONE;
         a = f_emit(a, qpx_pkg::CH_PCT, cap);
         if (held == ESC_DIGIT) begin
            a = f_plain(a, a.hd, cap);
         end
      end
      if (a.phase == PH_MATCH && a.mpos >= len) begin
         a.fflag = 1'b1;
      end
      a.st    = 1'b1;
      a.fnd   = a.fflag;
      a.phase = PH_MATCH;
      a.mpos  = 4'd0;
      a.esc   = ESC_NONE;
      a.hd    = 8'd0;
      a.cnt   = 8'd0;
      a.fflag = 1'b0;
      return a;
   endfunction

   assign len_eff   = (name_len_ff > 4'(NAME_MAX_BYTES)) ? 4'(NAME_MAX_BYTES) : name_len_ff;
   assign req_ready = ~q_full & ~reset;
   assign accept    = req_valid & req_ready;

   always_comb begin
      acc.phase = phase_ff;
      acc.mpos  = mpos_ff;
      acc.esc   = esc_ff;
      acc.hd    = hd_ff;
      acc.cnt   = cnt_ff;
      acc.fflag = fflag_ff;
      acc.vals  = '0;
      acc.nv    = 2'd0;
      acc.st    = 1'b0;
      acc.fnd   = 1'b0;
      if (req_ch == qpx_pkg::CH_NUL) begin
         acc = f_finish(acc, cap_ff, len_eff);
      end else begin
         acc = f_process(acc, req_ch, cap_ff, len_eff, name_ff);
         if (req_is_last) begin
            acc = f_finish(acc, cap_ff, len_eff);
         end
      end
   end

   assign q_push      = accept & ((acc.nv != 2'd0) | acc.st);
   assign q_data.vals = acc.vals;
   assign q_data.nv   = acc.nv;
   assign q_data.st   = acc.st;
   assign q_data.fnd  = acc.fnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff     <= '0;
         name_len_ff <= 4'd0;
         cap_ff      <= qpx_pkg::CAPACITY_RESET;
         phase_ff    <= PH_MATCH;
         mpos_ff     <= 4'd0;
         esc_ff      <= ESC_NONE;
         hd_ff       <= 8'd0;
         cnt_ff      <= 8'd0;
         fflag_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               qpx_pkg::CSR_NAME_BYTES:     name_ff     <= csr_wdata[NAME_BITS-1:0];
               qpx_pkg::CSR_NAME_LENGTH:    name_len_ff <= csr_wdata[3:0];
               qpx_pkg::CSR_VALUE_CAPACITY: cap_ff      <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            phase_ff <= acc.phase;
            mpos_ff  <= acc.mpos;
            esc_ff   <= acc.esc;
            hd_ff    <= acc.hd;
            cnt_ff   <= acc.cnt;
            fflag_ff <= acc.fflag;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/qpx_fifo.sv =====
// ----------------------------------------------------------------------------
// qpx_fifo
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpx_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qpx_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output qpx_pkg::bundle_type head
);

   localparam int unsigned DEPTH = qpx_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   qpx_pkg::bundle_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff;
   logic [PTR_W-1:0]    rd_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (do_push & ~do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop & ~do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/qpx_back.sv =====
// ----------------------------------------------------------------------------
// qpx_back
// Holds one bundle in the output register and hands its results out one
// item per cycle while the output is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  qpx_pkg::bundle_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_found,
   output logic                rsp_run_end
);

   qpx_pkg::bundle_type cur_ff;
   logic                busy_ff;
   logic [1:0]          idx_ff;
   logic                last_now;
   logic                done;
   logic                load;

   assign last_now = cur_ff.st ? (idx_ff == cur_ff.nv) : (idx_ff == cur_ff.nv - 2'd1);
   assign done     = busy_ff & rsp_ready & last_now;
   assign load     = q_not_empty & (~busy_ff | done);
   assign q_pop    = load;

   assign rsp_valid    = busy_ff;
   assign rsp_kind     = (idx_ff >= cur_ff.nv);
   assign rsp_out_byte = rsp_kind ? 8'd0 : cur_ff.vals[idx_ff];
   assign rsp_found    = rsp_kind & cur_ff.fnd;
   assign rsp_run_end  = last_now;

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= 2'd0;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (busy_ff & rsp_ready) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/qpx_checker.sv =====
// ----------------------------------------------------------------------------
// qpx_checker
// Port-level checks on the result channel of the extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qpx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_found,
   input logic       rsp_run_end
);

   `QPX_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte))
   `QPX_ASSERT_IMP(a_status_ends_run, clock, reset, rsp_valid && rsp_kind, rsp_run_end && rsp_out_byte == 8'd0)
   `QPX_ASSERT_IMP(a_value_not_found, clock, reset, rsp_valid && !rsp_kind, !rsp_found)
   `QPX_ASSERT_IMP(a_quiet_after_reset, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind url_query_param_extract qpx_checker u_qpx_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.kind),
   .rsp_out_byte (rsp_bus.out_byte),
   .rsp_found    (rsp_bus.found),
   .rsp_run_end  (rsp_bus.run_end)
);

`default_nettype wire
